// File: sv/pwcd_pkg.sv
// Shared types, constants and helpers for the pulse width code decoder.
`timescale 1ns / 1ps

package pwcd_pkg;

  // Configuration register widths.
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned DurW     = 20;
  // Compare width: wide enough for 47 * 65535.
  localparam int unsigned CmpW     = 22;
  localparam int unsigned CfgIdxW  = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegShort   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLong    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTol     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinBits = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0]  ShortTimeRst = 16'd350;
  localparam logic [TimeW-1:0]  LongTimeRst  = 16'd700;
  localparam logic [TimeW-1:0]  ToleranceRst = 16'd100;
  localparam logic [CountW-1:0] MinBitsRst   = 7'd24;

  // Fixed multiples used by the matching windows.
  localparam int unsigned PreambleUnits = 47;
  localparam int unsigned GapUnits      = 10;
  localparam int unsigned LongTolUnits  = 3;

  localparam int unsigned CodeWidthDef  = 64;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Register values plus the products derived from them.
  typedef struct packed {
    logic [TimeW-1:0]  short_time;
    logic [TimeW-1:0]  long_time;
    logic [TimeW-1:0]  tolerance;
    logic [CmpW-1:0]   tol3;      // 3 * tolerance
    logic [CmpW-1:0]   pre_nom;   // 47 * short_time
    logic [CmpW-1:0]   pre_win;   // 47 * tolerance
    logic [CmpW-1:0]   end_thr;   // 10 * short_time + tolerance
    logic [CountW-1:0] min_bits;
  } pwcd_cfg_t;

  // True when |d - nominal| < window.
  function automatic logic near(logic [CmpW-1:0] d, logic [CmpW-1:0] nominal,
                                logic [CmpW-1:0] window);
    logic [CmpW-1:0] diff;
    diff = (d > nominal) ? (d - nominal) : (nominal - d);
    return diff < window;
  endfunction

endpackage

// File: sv/pwcd_cfg.sv
// Configuration registers and the products derived from them.
`timescale 1ns / 1ps

module pwcd_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pwcd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pwcd_pkg::TimeW-1:0]        cfg_data_i,
  output pwcd_pkg::pwcd_cfg_t               cfg_o
);
  import pwcd_pkg::*;

  localparam logic [CmpW-1:0] Tol3Rst   = CmpW'(LongTolUnits * ToleranceRst);
  localparam logic [CmpW-1:0] PreNomRst = CmpW'(PreambleUnits * ShortTimeRst);
  localparam logic [CmpW-1:0] PreWinRst = CmpW'(PreambleUnits * ToleranceRst);
  localparam logic [CmpW-1:0] EndThrRst =
      CmpW'(GapUnits * ShortTimeRst + ToleranceRst);

  pwcd_cfg_t cfg_q, cfg_d;
  logic [CmpW-1:0] data_ext;

  assign data_ext = CmpW'(cfg_data_i);

  // Recompute the derived products together with the written register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegShort: begin
          cfg_d.short_time = cfg_data_i;
          cfg_d.pre_nom    = CmpW'(data_ext * CmpW'(PreambleUnits));
          cfg_d.end_thr    = CmpW'(data_ext * CmpW'(GapUnits))
                             + CmpW'(cfg_q.tolerance);
        end
        RegLong: begin
          cfg_d.long_time = cfg_data_i;
        end
        RegTol: begin
          cfg_d.tolerance = cfg_data_i;
          cfg_d.tol3      = CmpW'(data_ext * CmpW'(LongTolUnits));
          cfg_d.pre_win   = CmpW'(data_ext * CmpW'(PreambleUnits));
          cfg_d.end_thr   = CmpW'(CmpW'(cfg_q.short_time) * CmpW'(GapUnits))
                            + data_ext;
        end
        RegMinBits: begin
          cfg_d.min_bits = cfg_data_i[CountW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_time <= ShortTimeRst;
      cfg_q.long_time  <= LongTimeRst;
      cfg_q.tolerance  <= ToleranceRst;
      cfg_q.tol3       <= Tol3Rst;
      cfg_q.pre_nom    <= PreNomRst;
      cfg_q.pre_win    <= PreWinRst;
      cfg_q.end_thr    <= EndThrRst;
      cfg_q.min_bits   <= MinBitsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/pulse_width_code_decoder_top.sv
// Top level of the pulse width code decoder.
`timescale 1ns / 1ps

// Pulse width code decoder. Each request on the slave stream is one radio
// level segment (level bit and duration in microseconds); the block hunts
// for a long low preamble, then a long high start pulse, then decodes pairs
// of low/high segments (short-long is a 0, long-short is a 1) into a
// CODE_WIDTH bit shift register, newest bit in bit 0. A long low gap closes
// the frame and, when at least min_bits bits arrived, one request carrying
// the code and the saturated bit count goes out on the master stream.
// A segment is taken into an input register, decoded by one level of
// compare logic and its result lands in an output register; one segment
// is accepted every clock while results are taken, so the rate is one
// segment per cycle, and a result is valid once its segment has moved
// on into the output register. A result held by the sink stalls the
// segment stream once the input register is also occupied.
// Configuration writes take effect at the next edge and belong in idle time.

module pulse_width_code_decoder_top #(
  parameter int unsigned CODE_WIDTH = pwcd_pkg::CodeWidthDef,
  localparam int unsigned OutW = ((CODE_WIDTH + pwcd_pkg::CountW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Segment stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // level[0], duration[20:1], zero pad
  // Code stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutW-1:0]               m_axis_tdata,  // code, bit_count, zero pad
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [pwcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwcd_pkg::TimeW-1:0]    cfg_data_i
);
  import pwcd_pkg::*;

  // Decoder phases.
  localparam logic [1:0] PhPreamble = 2'd0;
  localparam logic [1:0] PhStart    = 2'd1;
  localparam logic [1:0] PhLow      = 2'd2;
  localparam logic [1:0] PhHigh     = 2'd3;

  pwcd_cfg_t cfg;

  pwcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Input register.
  logic              in_vld_q;
  logic              lvl_q;
  logic [DurW-1:0]   dur_q;

  // Decoder state.
  logic [1:0]             phase_q, phase_d;
  logic [CODE_WIDTH-1:0]  shift_q, shift_d;
  logic [CountW-1:0]      seen_q, seen_d;
  logic [DurW-1:0]        low_q, low_d;

  // Output register.
  logic                   out_vld_q;
  logic [CODE_WIDTH-1:0]  code_q;
  logic [CountW-1:0]      cnt_q;

  logic step;      // the held segment is decoded at this edge
  logic emit;      // the decoded segment closes a reportable frame
  logic push;
  logic push_bit;

  logic [CmpW-1:0] d_ext, lo_ext, st_ext, lt_ext, tol_ext;
  logic pre_ok, start_ok, gap, lo_short, lo_long, d_short, d_long;

  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  assign d_ext   = CmpW'(dur_q);
  assign lo_ext  = CmpW'(low_q);
  assign st_ext  = CmpW'(cfg.short_time);
  assign lt_ext  = CmpW'(cfg.long_time);
  assign tol_ext = CmpW'(cfg.tolerance);

  assign pre_ok   = !lvl_q && near(d_ext, cfg.pre_nom, cfg.pre_win);
  assign start_ok = lvl_q && near(d_ext, lt_ext, cfg.tol3);
  assign gap      = d_ext >= cfg.end_thr;
  assign lo_short = near(lo_ext, st_ext, tol_ext);
  assign lo_long  = near(lo_ext, lt_ext, cfg.tol3);
  assign d_short  = near(d_ext, st_ext, tol_ext);
  assign d_long   = near(d_ext, lt_ext, cfg.tol3);

  // Next state for the held segment.
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    seen_d   = seen_q;
    low_d    = low_q;
    emit     = 1'b0;
    push     = 1'b0;
    push_bit = 1'b0;
    unique case (phase_q)
      PhPreamble: begin
        if (pre_ok) begin
          phase_d = PhStart;
        end
      end
      PhStart: begin
        // A miss here drops back without re-examining the segment.
        if (start_ok) begin
          phase_d = PhLow;
          shift_d = '0;
          seen_d  = '0;
        end else begin
          phase_d = PhPreamble;
        end
      end
      PhLow: begin
        // High segments are ignored while waiting for the low half.
        if (!lvl_q) begin
          if (gap) begin
            phase_d = PhStart;
            emit    = seen_q >= cfg.min_bits;
            shift_d = '0;
            seen_d  = '0;
          end else begin
            low_d   = dur_q;
            phase_d = PhHigh;
          end
        end
      end
      PhHigh: begin
        priority if (lvl_q && lo_short && d_long) begin
          push     = 1'b1;
          push_bit = 1'b0;
          phase_d  = PhLow;
        end else if (lvl_q && lo_long && d_short) begin
          push     = 1'b1;
          push_bit = 1'b1;
          phase_d  = PhLow;
        end else begin
          phase_d = PhPreamble;
        end
      end
      default: begin
        phase_d = PhPreamble;
      end
    endcase
    if (push) begin
      shift_d = {shift_q[CODE_WIDTH-2:0], push_bit};
      // Saturate the count; the register keeps shifting.
      if (seen_q != CountMax) begin
        seen_d = seen_q + CountW'(1);
      end
    end
  end

  // Input register: take a segment whenever the slot frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      lvl_q <= s_axis_tdata[0];
      dur_q <= s_axis_tdata[DurW:1];
    end
  end

  // Decoder state advances once per decoded segment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPreamble;
      shift_q <= '0;
      seen_q  <= '0;
      low_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      seen_q  <= seen_d;
      low_q   <= low_d;
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= emit;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      code_q <= shift_q;
      cnt_q  <= seen_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({cnt_q, code_q});

endmodule

// File: sv/pwcd_checker.sv
// Port-level checks for the pulse width code decoder, bound to the top level.
`timescale 1ns / 1ps

module pwcd_checker #(
  parameter int unsigned CODE_WIDTH = pwcd_pkg::CodeWidthDef,
  localparam int unsigned OutW = ((CODE_WIDTH + pwcd_pkg::CountW + 7) / 8) * 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [OutW-1:0]               m_axis_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the output register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A fresh result traces back to a segment accepted through the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching segment");

  // Pad bits above the bit count stay zero.
  a_count_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> (CODE_WIDTH + pwcd_pkg::CountW)) == '0)
    else $error("pad bits set in result");

endmodule

bind pulse_width_code_decoder_top pwcd_checker #(.CODE_WIDTH(CODE_WIDTH)) u_pwcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
